// ===== rtl/clle_pkg.sv =====
// Shared constants and types for the circular linked list engine.
// No dependencies; imported by every module of the block.
package clle_pkg;

  localparam int ID_WIDTH_DEF = 12;
  localparam int MODE_W       = 3;

  localparam logic [MODE_W-1:0] MODE_LOAD       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_AFTER  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INS_BEFORE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEL_NEXT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEL_PREV   = 3'd4;

  typedef struct packed {
    logic en;
    logic we;
  } ram_ctl_t;

endpackage

// ===== rtl/clle_ram.sv =====
// Single-port synchronous RAM, one access per cycle, registered read data.
// Depends on clle_pkg for the access control struct.
module clle_ram #(
  parameter int AW = clle_pkg::ID_WIDTH_DEF,
  parameter int DW = clle_pkg::ID_WIDTH_DEF
) (
  input  logic              clk,
  input  clle_pkg::ram_ctl_t ctl,
  input  logic [AW-1:0]     addr,
  input  logic [DW-1:0]     wdata,
  output logic [DW-1:0]     rdata
);
  import clle_pkg::*;

  logic [DW-1:0] mem [(1 << AW)];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/clle_ctrl.sv =====
// Command sequencer: reads links, writes them back, holds ring ends and result beat.
// Depends on clle_pkg; drives the next and previous link RAMs.
module clle_ctrl #(
  parameter int ID_WIDTH = clle_pkg::ID_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [clle_pkg::MODE_W-1:0] in_mode,
  input  logic [ID_WIDTH-1:0]         in_node_id,
  input  logic [ID_WIDTH-1:0]         in_new_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ID_WIDTH-1:0]         out_neighbour_id,
  output clle_pkg::ram_ctl_t          nt_ctl,
  output logic [ID_WIDTH-1:0]         nt_addr,
  output logic [ID_WIDTH-1:0]         nt_wdata,
  input  logic [ID_WIDTH-1:0]         nt_rdata,
  output clle_pkg::ram_ctl_t          pt_ctl,
  output logic [ID_WIDTH-1:0]         pt_addr,
  output logic [ID_WIDTH-1:0]         pt_wdata,
  input  logic [ID_WIDTH-1:0]         pt_rdata
);
  import clle_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RDX  = 5'b00010,
    S_RDY  = 5'b00100,
    S_WR1  = 5'b01000,
    S_WR2  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [MODE_W-1:0]   mode_r;
  logic [ID_WIDTH-1:0] a_r, b_r, x_r, y_r;
  logic [ID_WIDTH-1:0] head_r, tail_r;
  logic                started_r;
  logic                out_valid_r;
  logic [ID_WIDTH-1:0] out_id_r;

  logic                sel_next, is_del, has_result, finish, hold, push;
  logic [ID_WIDTH-1:0] rd_x, head_eff;

  assign sel_next   = (mode_r == MODE_INS_AFTER) || (mode_r == MODE_DEL_NEXT);
  assign is_del     = (mode_r == MODE_DEL_NEXT) || (mode_r == MODE_DEL_PREV);
  assign has_result = (mode_r != MODE_LOAD);
  assign rd_x       = sel_next ? nt_rdata : pt_rdata;
  assign head_eff   = started_r ? head_r : a_r;
  assign finish     = (state_r == S_WR2) || ((state_r == S_WR1) && is_del);
  assign hold       = finish && has_result && out_valid_r && out_stall;
  assign push       = finish && has_result && !hold;

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_neighbour_id = out_id_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_mode) inside
            MODE_LOAD: state_nxt = S_WR1;
            MODE_INS_AFTER, MODE_INS_BEFORE, MODE_DEL_NEXT, MODE_DEL_PREV: state_nxt = S_RDX;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RDX: state_nxt = is_del ? S_RDY : S_WR1;
      S_RDY: state_nxt = S_WR1;
      S_WR1: begin
        if (!is_del) begin
          state_nxt = S_WR2;
        end else if (!hold) begin
          state_nxt = S_IDLE;
        end
      end
      S_WR2: begin
        if (!hold) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    nt_ctl   = '0;
    pt_ctl   = '0;
    nt_addr  = a_r;
    nt_wdata = b_r;
    pt_addr  = a_r;
    pt_wdata = b_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_mode) inside
            MODE_INS_AFTER, MODE_DEL_NEXT: begin
              nt_ctl.en = 1'b1;
              nt_addr   = in_node_id;
            end
            MODE_INS_BEFORE, MODE_DEL_PREV: begin
              pt_ctl.en = 1'b1;
              pt_addr   = in_node_id;
            end
            default: ;
          endcase
        end
      end
      S_RDX: begin
        if (mode_r == MODE_DEL_NEXT) begin
          nt_ctl.en = 1'b1;
          nt_addr   = rd_x;
        end else if (mode_r == MODE_DEL_PREV) begin
          pt_ctl.en = 1'b1;
          pt_addr   = rd_x;
        end
      end
      S_RDY: ;
      S_WR1: begin
        if (!hold) begin
          case (mode_r)
            MODE_LOAD: begin
              nt_ctl   = '{en: started_r, we: started_r};
              nt_addr  = tail_r;
              nt_wdata = a_r;
              pt_ctl   = '{en: started_r, we: started_r};
              pt_addr  = a_r;
              pt_wdata = tail_r;
            end
            MODE_INS_AFTER: begin
              nt_ctl   = '{en: 1'b1, we: 1'b1};
              nt_addr  = b_r;
              nt_wdata = x_r;
              pt_ctl   = '{en: 1'b1, we: 1'b1};
              pt_addr  = b_r;
              pt_wdata = a_r;
            end
            MODE_INS_BEFORE: begin
              nt_ctl   = '{en: 1'b1, we: 1'b1};
              nt_addr  = b_r;
              nt_wdata = a_r;
              pt_ctl   = '{en: 1'b1, we: 1'b1};
              pt_addr  = b_r;
              pt_wdata = x_r;
            end
            MODE_DEL_NEXT: begin
              nt_ctl   = '{en: 1'b1, we: 1'b1};
              nt_addr  = a_r;
              nt_wdata = y_r;
              pt_ctl   = '{en: 1'b1, we: 1'b1};
              pt_addr  = y_r;
              pt_wdata = a_r;
            end
            MODE_DEL_PREV: begin
              pt_ctl   = '{en: 1'b1, we: 1'b1};
              pt_addr  = a_r;
              pt_wdata = y_r;
              nt_ctl   = '{en: 1'b1, we: 1'b1};
              nt_addr  = y_r;
              nt_wdata = a_r;
            end
            default: ;
          endcase
        end
      end
      S_WR2: begin
        if (!hold) begin
          case (mode_r)
            MODE_LOAD: begin
              nt_ctl   = '{en: 1'b1, we: 1'b1};
              nt_addr  = a_r;
              nt_wdata = head_eff;
              pt_ctl   = '{en: 1'b1, we: 1'b1};
              pt_addr  = head_eff;
              pt_wdata = a_r;
            end
            MODE_INS_AFTER: begin
              nt_ctl   = '{en: 1'b1, we: 1'b1};
              nt_addr  = a_r;
              nt_wdata = b_r;
              pt_ctl   = '{en: 1'b1, we: 1'b1};
              pt_addr  = x_r;
              pt_wdata = b_r;
            end
            MODE_INS_BEFORE: begin
              nt_ctl   = '{en: 1'b1, we: 1'b1};
              nt_addr  = x_r;
              nt_wdata = b_r;
              pt_ctl   = '{en: 1'b1, we: 1'b1};
              pt_addr  = a_r;
              pt_wdata = b_r;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_WR2) && (mode_r == MODE_LOAD)) begin
        head_r    <= head_eff;
        tail_r    <= a_r;
        started_r <= 1'b1;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) begin
      mode_r <= in_mode;
      a_r    <= in_node_id;
      b_r    <= in_new_id;
    end
    if (state_r == S_RDX) begin
      x_r <= rd_x;
    end
    if (state_r == S_RDY) begin
      y_r <= rd_x;
    end
    if (push) begin
      out_id_r <= x_r;
    end
  end

endmodule

// ===== rtl/circular_linked_list_engine_unit.sv =====
// Circular doubly linked list engine: sequencer plus next and previous link RAMs.
// Depends on clle_pkg, clle_ctrl and clle_ram.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat carries in_mode, in_node_id and
//   in_new_id. Load beats append a node behind the last loaded one and give no
//   result. Insert beats give the old neighbour; delete beats give the removed id.
//   Result channel (out_valid / out_stall): one beat of out_neighbour_id.
//   Sequencing: a beat is taken only while the sequencer is idle. A load does
//   two write steps, an insert one link read then two write steps, a delete two
//   dependent link reads then one write step; unused modes are taken and dropped
//   while idle. The single port of each link RAM sets this order. The result
//   shows in the output register the cycle after the last write and waits there
//   while the next command is taken.
//   Stall: if the previous result still waits under out_stall when a new one
//   is ready, the sequencer holds in its last write cycle until it is taken.
//   Reset: synchronous, active low; clears the ring ends and the result flag.
//   The link RAMs are not cleared; the user, not the block, must write entries before they are read.
module circular_linked_list_engine_unit #(
  parameter int ID_WIDTH = clle_pkg::ID_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [clle_pkg::MODE_W-1:0] in_mode,
  input  logic [ID_WIDTH-1:0]         in_node_id,
  input  logic [ID_WIDTH-1:0]         in_new_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ID_WIDTH-1:0]         out_neighbour_id
);
  import clle_pkg::*;

  ram_ctl_t            nt_ctl, pt_ctl;
  logic [ID_WIDTH-1:0] nt_addr, nt_wdata, nt_rdata;
  logic [ID_WIDTH-1:0] pt_addr, pt_wdata, pt_rdata;

  clle_ctrl #(.ID_WIDTH(ID_WIDTH)) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_node_id       (in_node_id),
    .in_new_id        (in_new_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_neighbour_id (out_neighbour_id),
    .nt_ctl           (nt_ctl),
    .nt_addr          (nt_addr),
    .nt_wdata         (nt_wdata),
    .nt_rdata         (nt_rdata),
    .pt_ctl           (pt_ctl),
    .pt_addr          (pt_addr),
    .pt_wdata         (pt_wdata),
    .pt_rdata         (pt_rdata)
  );

  clle_ram #(.AW(ID_WIDTH), .DW(ID_WIDTH)) u_next_ram (
    .clk   (clk),
    .ctl   (nt_ctl),
    .addr  (nt_addr),
    .wdata (nt_wdata),
    .rdata (nt_rdata)
  );

  clle_ram #(.AW(ID_WIDTH), .DW(ID_WIDTH)) u_prev_ram (
    .clk   (clk),
    .ctl   (pt_ctl),
    .addr  (pt_addr),
    .wdata (pt_wdata),
    .rdata (pt_rdata)
  );

endmodule

// ===== rtl/clle_checker.sv =====
// Port-level checks for the circular linked list engine, bound to the top level.
// Depends on clle_pkg and circular_linked_list_engine_unit.
module clle_checker #(
  parameter int ID_WIDTH = clle_pkg::ID_WIDTH_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [clle_pkg::MODE_W-1:0] in_mode,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [ID_WIDTH-1:0]         out_neighbour_id
);
  import clle_pkg::*;

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("outputs not cleared after reset");

  a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode == MODE_LOAD || in_mode == MODE_INS_AFTER ||
      in_mode == MODE_INS_BEFORE || in_mode == MODE_DEL_NEXT || in_mode == MODE_DEL_PREV)
    |=> in_stall)
    else $error("command taken without occupying the sequencer");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without a command in flight");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_neighbour_id))
    else $error("stalled result beat changed");

endmodule

bind circular_linked_list_engine_unit clle_checker #(.ID_WIDTH(ID_WIDTH)) u_clle_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_mode          (in_mode),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_neighbour_id (out_neighbour_id)
);

// ===== sim/circular_linked_list_engine_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for circular_linked_list_engine_unit: queued driver, clocked
// monitor and an in-bench link table tracker that predicts every neighbour id.
// Depends on clle_pkg and the engine RTL.
module circular_linked_list_engine_unit_test;
  import clle_pkg::*;

  localparam int IDW   = ID_WIDTH_DEF;
  localparam int NODES = 1 << IDW;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
  localparam int RAND_CMDS = 500;
  localparam int PHASE_A   = 180;
  localparam int PHASE_B   = 360;
  localparam int HOLD_AT   = 420;
  localparam int HOLD_LEN  = 300;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDW-1:0]    node;
    logic [IDW-1:0]    nid;
  } link_cmd_t;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] in_mode    = MODE_LOAD;
  logic [IDW-1:0]    in_node_id = '0;
  logic [IDW-1:0]    in_new_id  = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [IDW-1:0]    out_neighbour_id;

  // link table tracker
  logic [IDW-1:0] link_nxt [NODES];
  logic [IDW-1:0] link_prv [NODES];
  bit             wr_nxt   [NODES];
  bit             wr_prv   [NODES];
  logic [IDW-1:0] ring_head;
  logic [IDW-1:0] ring_tail;
  bit             ring_live;

  link_cmd_t      pend_q[$];
  logic [IDW-1:0] nbr_expect[$];
  int             node_pool[$];
  link_cmd_t      cur_cmd;
  logic [IDW-1:0] nbr_want;

  int beats_taken  = 0;
  int n_load       = 0;
  int n_ins        = 0;
  int n_del        = 0;
  int n_spare      = 0;
  int n_checked    = 0;
  int stall_cycles = 0;
  int err_cnt      = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  circular_linked_list_engine_unit #(.ID_WIDTH(IDW)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_node_id       (in_node_id),
    .in_new_id        (in_new_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_neighbour_id (out_neighbour_id)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic set_nxt(input logic [IDW-1:0] idx, input logic [IDW-1:0] val);
    link_nxt[idx] = val;
    wr_nxt[idx]   = 1'b1;
  endtask

  task automatic set_prv(input logic [IDW-1:0] idx, input logic [IDW-1:0] val);
    link_prv[idx] = val;
    wr_prv[idx]   = 1'b1;
  endtask

  task automatic apply_link_cmd(input logic [MODE_W-1:0] mode, input logic [IDW-1:0] a,
                                input logic [IDW-1:0] b);
    logic [IDW-1:0] x;
    logic [IDW-1:0] y;
    case (mode)
      MODE_LOAD: begin
        if (!ring_live) begin
          ring_head = a;
          ring_live = 1'b1;
        end else begin
          set_nxt(ring_tail, a);
          set_prv(a, ring_tail);
        end
        set_nxt(a, ring_head);
        set_prv(ring_head, a);
        ring_tail = a;
      end
      MODE_INS_AFTER: begin
        x = link_nxt[a];
        set_nxt(b, x);
        set_prv(b, a);
        set_prv(x, b);
        set_nxt(a, b);
        nbr_expect.push_back(x);
      end
      MODE_INS_BEFORE: begin
        x = link_prv[a];
        set_prv(b, x);
        set_nxt(b, a);
        set_nxt(x, b);
        set_prv(a, b);
        nbr_expect.push_back(x);
      end
      MODE_DEL_NEXT: begin
        x = link_nxt[a];
        y = link_nxt[x];
        set_nxt(a, y);
        set_prv(y, a);
        nbr_expect.push_back(x);
      end
      MODE_DEL_PREV: begin
        x = link_prv[a];
        y = link_prv[x];
        set_prv(a, y);
        set_nxt(y, a);
        nbr_expect.push_back(x);
      end
      default: ;
    endcase
  endtask

  // true when every link the command reads has been written
  function automatic bit cmd_legal(input logic [MODE_W-1:0] mode, input logic [IDW-1:0] a);
    case (mode)
      MODE_INS_AFTER:  return wr_nxt[a];
      MODE_INS_BEFORE: return wr_prv[a];
      MODE_DEL_NEXT:   return wr_nxt[a] && wr_nxt[link_nxt[a]];
      MODE_DEL_PREV:   return wr_prv[a] && wr_prv[link_prv[a]];
      default:         return 1'b1;
    endcase
  endfunction

  task automatic queue_cmd(input logic [MODE_W-1:0] mode, input int a, input int b);
    link_cmd_t c;
    c.mode = cmd_legal(mode, a[IDW-1:0]) ? mode : MODE_LOAD;
    c.node = a[IDW-1:0];
    c.nid  = b[IDW-1:0];
    if (c.mode == MODE_LOAD)
      node_pool.push_back(a);
    else if (c.mode == MODE_INS_AFTER || c.mode == MODE_INS_BEFORE)
      node_pool.push_back(b);
    pend_q.push_back(c);
    apply_link_cmd(c.mode, c.node, c.nid);
  endtask

  task automatic ring_clear();
    for (int i = 0; i < NODES; i++) begin
      link_nxt[i] = '0;
      link_prv[i] = '0;
      wr_nxt[i]   = 1'b0;
      wr_prv[i]   = 1'b0;
    end
    ring_head = '0;
    ring_tail = '0;
    ring_live = 1'b0;
    nbr_expect.delete();
  endtask

  function automatic int send_idle_pct(input int taken);
    if (taken < PHASE_A) return 9;
    if (taken < PHASE_B) return 54;
    return 0;
  endfunction

  function automatic int recv_idle_pct(input int taken);
    if (taken < PHASE_A) return 54;
    if (taken < PHASE_B) return 9;
    return 0;
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // driver: advance on accept, hold while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_link_cmd(in_mode, in_node_id, in_new_id);
        beats_taken <= beats_taken + 1;
        case (in_mode)
          MODE_LOAD:                      n_load <= n_load + 1;
          MODE_INS_AFTER, MODE_INS_BEFORE: n_ins <= n_ins + 1;
          MODE_DEL_NEXT, MODE_DEL_PREV:   n_del <= n_del + 1;
          default:                        n_spare <= n_spare + 1;
        endcase
      end
      if (in_valid && in_stall)
        stall_cycles <= stall_cycles + 1;
      if (!in_valid || !in_stall) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct(beats_taken)) begin
          cur_cmd = pend_q.pop_front();
          in_mode    <= cur_cmd.mode;
          in_node_id <= cur_cmd.node;
          in_new_id  <= cur_cmd.nid;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off in the last phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && beats_taken >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct(beats_taken));
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (nbr_expect.size() == 0) begin
        note_mismatch("unexpected result beat", -1, out_neighbour_id);
      end else begin
        nbr_want = nbr_expect.pop_front();
        n_checked <= n_checked + 1;
        if (out_neighbour_id !== nbr_want)
          note_mismatch("neighbour_id", nbr_want, out_neighbour_id);
      end
    end
  end

  initial begin
    int made;
    int r;
    int a;
    int b;
    logic [MODE_W-1:0] m;

    queue_cmd(MODE_LOAD, NODES - 1, 0);
    queue_cmd(MODE_LOAD, 1, NODES - 1);
    queue_cmd(MODE_LOAD, 'hAAA, 'h555);
    queue_cmd(MODE_LOAD, 'h555, 'hAAA);
    queue_cmd(MODE_INS_AFTER, 1, 0);
    queue_cmd(MODE_INS_BEFORE, NODES - 1, NODES - 2);
    queue_cmd(MODE_DEL_NEXT, 1, 0);
    queue_cmd(MODE_DEL_PREV, NODES - 1, 0);
    queue_cmd(MODE_UNUSED_LO, 1, NODES - 1);
    queue_cmd(MODE_UNUSED_LO + 3'd1, NODES - 1, 0);
    queue_cmd(MODE_UNUSED_HI, 'hAAA, 'hAAA);
    queue_cmd(MODE_INS_AFTER, 'hAAA, 'hAAA);
    queue_cmd(MODE_INS_BEFORE, 'h555, 1);
    queue_cmd(MODE_DEL_NEXT, NODES - 1, 0);
    queue_cmd(MODE_DEL_PREV, 1, 0);
    queue_cmd(MODE_LOAD, 100, 0);
    queue_cmd(MODE_INS_AFTER, NODES - 1, NODES - 1);
    for (int i = 0; i < 5; i++)
      queue_cmd(MODE_DEL_NEXT, NODES - 1, 0);
    queue_cmd(MODE_DEL_PREV, NODES - 1, 0);
    queue_cmd(MODE_LOAD, NODES - 1, NODES - 1);

    made = 0;
    while (made < RAND_CMDS) begin
      r = $urandom_range(99);
      if (r < 5) begin
        m = MODE_UNUSED_LO + 3'($urandom_range(2));
        queue_cmd(m, $urandom_range(NODES - 1, 1), $urandom_range(NODES - 1));
      end else if (r < 20) begin
        queue_cmd(MODE_LOAD, $urandom_range(NODES - 1, 1), $urandom_range(NODES - 1));
        made++;
      end else begin
        m = MODE_INS_AFTER + 3'($urandom_range(3));
        a = node_pool[$urandom_range(node_pool.size() - 1)];
        if ($urandom_range(3) == 0)
          b = node_pool[$urandom_range(node_pool.size() - 1)];
        else
          b = $urandom_range(NODES - 1);
        if (a != 0 && cmd_legal(m, a[IDW-1:0])) begin
          queue_cmd(m, a, b);
          made++;
        end
      end
    end
    ring_clear();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_valid)
      @(posedge clk);
    while (nbr_expect.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (nbr_expect.size() != 0)
      note_mismatch("results still owed", nbr_expect.size(), 0);

    $display("Ran %0d beats: %0d loads, %0d inserts, %0d deletes, %0d unused modes.",
             beats_taken, n_load, n_ins, n_del, n_spare);
    $display("Checked %0d neighbour ids; input held off for %0d cycles; %0d mismatches.",
             n_checked, stall_cycles, err_cnt);
    if (err_cnt == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout after %0d beats and %0d checked results.", beats_taken, n_checked);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
